// ===== rtl/msh_pkg.sv =====
package msh_pkg;

   localparam int CMD_W      = 1;
   localparam int KEY_PORT_W = 16;
   localparam int SLOT_W     = 6;
   localparam int STAT_W     = 2;
   localparam int MID_W      = 7;
   localparam int TSIZE_W    = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

   localparam logic [STAT_W-1:0] STAT_STORED   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ZERO_KEY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_READ     = 2'd3;

   localparam logic [TSIZE_W-1:0]    TSIZE_RESET         = 7'd64;
   localparam logic [CSR_ADDR_W-1:0] CSR_TABLE_SIZE_ADDR = 2'd0;

   // largest two-digit middle value
   localparam logic [MID_W-1:0] MID_MAX = 7'd99;

   typedef logic [3:0] bcd_digit_type;

endpackage

// ===== rtl/msh_bcd.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
module msh_bcd #(
   parameter int IN_W = 32,
   parameter int NDIG = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [IN_W-1:0]                       value,
   output logic                                  done,
   output msh_pkg::bcd_digit_type [NDIG-1:0]     digits
);
   import msh_pkg::*;

   localparam int CNT_W = $clog2(IN_W);
   localparam int BCD_W = NDIG * 4;

   bcd_digit_type [NDIG-1:0] bcd_ff, bcd_in, adj;
   logic [IN_W-1:0]          bin_ff, bin_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     run_ff, run_in;
   logic                     done_ff, done_in;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_in  = bcd_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bcd_in = '0;
         bin_in = value;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in = BCD_W'({adj, bin_ff[IN_W-1]});
         bin_in = {bin_ff[IN_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(IN_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== rtl/msh_table.sv =====
// Slot store: one write port, one registered read port. Per-entry valid
// bits make every slot read as empty right after reset.
module msh_table #(
   parameter int DEPTH  = 64,
   parameter int IDX_W  = 6,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/mid_square_hash_linear_probe.sv =====
// Insert: squaring, decimal conversion of the square, middle-digit pick,
// remainder, then a table read and a check for each slot probed, P = slots
// probed (1 to table size). Read: one table read and check; zero key: no hashing.
// One word in flight; a new word is taken while the last result waits.
// Synchronous reset empties every slot at once and sets table_size to 64.
module mid_square_hash_linear_probe #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_WIDTH   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [msh_pkg::CMD_W-1:0]          req_cmd,
   input  logic [msh_pkg::KEY_PORT_W-1:0]     req_key,
   input  logic [msh_pkg::SLOT_W-1:0]         req_slot,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [msh_pkg::STAT_W-1:0]         rsp_status,
   output logic [msh_pkg::SLOT_W-1:0]         rsp_placed_slot,
   output logic [msh_pkg::SLOT_W-1:0]         rsp_home_slot,
   output logic [msh_pkg::MID_W-1:0]          rsp_mid_value,
   output logic [msh_pkg::KEY_PORT_W-1:0]     rsp_read_key,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msh_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [msh_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import msh_pkg::*;

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int SZ_W      = $clog2(TABLE_DEPTH + 1);
   localparam int REM_W     = SZ_W + 1;
   localparam int SQ_W      = 2 * KEY_WIDTH;
   localparam int NDIG      = (SQ_W * 30103) / 100000 + 1;
   localparam int DIG_IDX_W = $clog2(NDIG);
   localparam int MOD_CNT_W = $clog2(MID_W + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SQ      = 4'd1;
   localparam logic [3:0] S_BCD_ST  = 4'd2;
   localparam logic [3:0] S_BCD     = 4'd3;
   localparam logic [3:0] S_MID     = 4'd4;
   localparam logic [3:0] S_MOD     = 4'd5;
   localparam logic [3:0] S_PRB_RD  = 4'd6;
   localparam logic [3:0] S_PRB_CHK = 4'd7;
   localparam logic [3:0] S_RD      = 4'd8;
   localparam logic [3:0] S_RD_CHK  = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]             state_ff, state_in;
   logic [TSIZE_W-1:0]     table_size_ff, table_size_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [MID_W-1:0]       div_ff, div_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SZ_W-1:0]        probe_cnt_ff, probe_cnt_in;

   logic [STAT_W-1:0]      w_status_ff, w_status_in;
   logic [SLOT_W-1:0]      w_placed_ff, w_placed_in;
   logic [SLOT_W-1:0]      w_home_ff, w_home_in;
   logic [MID_W-1:0]       w_mid_ff, w_mid_in;
   logic [KEY_PORT_W-1:0]  w_rkey_ff, w_rkey_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]      out_status_ff, out_status_in;
   logic [SLOT_W-1:0]      out_placed_ff, out_placed_in;
   logic [SLOT_W-1:0]      out_home_ff, out_home_in;
   logic [MID_W-1:0]       out_mid_ff, out_mid_in;
   logic [KEY_PORT_W-1:0]  out_rkey_ff, out_rkey_in;

   logic [SZ_W-1:0]        eff_size;
   logic [SZ_W-1:0]        idx_inc;
   logic [REM_W-1:0]       rem_shift, rem_next;
   logic                   slot_ok;
   logic                   csr_wr;

   logic                   bcd_start, bcd_done;
   bcd_digit_type [NDIG-1:0] digits;
   logic [DIG_IDX_W-1:0]   top_dig, half, half_up;
   bcd_digit_type          dig_hi, dig_lo;
   logic [MID_W-1:0]       mid_sel;

   logic                   tbl_rd_en, tbl_wr_en;
   logic [IDX_W-1:0]       tbl_rd_addr;
   logic [KEY_WIDTH-1:0]   tbl_rd_data;

   msh_bcd #(
      .IN_W (SQ_W),
      .NDIG (NDIG)
   ) u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (sq_ff),
      .done   (bcd_done),
      .digits (digits)
   );

   msh_table #(
      .DEPTH  (TABLE_DEPTH),
      .IDX_W  (IDX_W),
      .DATA_W (KEY_WIDTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (idx_ff),
      .wr_data (key_ff)
   );

   // table size in effect: clamped to 1..TABLE_DEPTH
   always_comb begin
      if (table_size_ff == '0) begin
         eff_size = SZ_W'(1);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         eff_size = SZ_W'(TABLE_DEPTH);
      end else begin
         eff_size = SZ_W'(table_size_ff);
      end
   end

   // middle digit(s) of the square from the top nonzero BCD digit
   always_comb begin
      top_dig = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (digits[i] != '0) begin
            top_dig = DIG_IDX_W'(i);
         end
      end
      half    = top_dig >> 1;
      half_up = half + DIG_IDX_W'(1);
      dig_lo  = digits[half];
      dig_hi  = digits[half_up];
      if (!top_dig[0]) begin
         mid_sel = MID_W'(dig_lo);
      end else begin
         mid_sel = MID_W'({dig_hi, 3'b000}) + MID_W'({dig_hi, 1'b0}) + MID_W'(dig_lo);
      end
   end

   assign rem_shift = {rem_ff[REM_W-2:0], div_ff[MID_W-1]};
   assign rem_next  = (rem_shift >= REM_W'(eff_size)) ? rem_shift - REM_W'(eff_size)
                                                     : rem_shift;
   assign idx_inc   = SZ_W'(idx_ff) + SZ_W'(1);
   assign slot_ok   = 32'(slot_ff) < 32'(TABLE_DEPTH);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr == CSR_TABLE_SIZE_ADDR);

   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      sq_in         = sq_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      idx_in        = idx_ff;
      probe_cnt_in  = probe_cnt_ff;
      w_status_in   = w_status_ff;
      w_placed_in   = w_placed_ff;
      w_home_in     = w_home_ff;
      w_mid_in      = w_mid_ff;
      w_rkey_in     = w_rkey_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_placed_in = out_placed_ff;
      out_home_in   = out_home_ff;
      out_mid_in    = out_mid_ff;
      out_rkey_in   = out_rkey_ff;
      bcd_start     = 1'b0;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = idx_ff;
      tbl_wr_en     = 1'b0;

      if (csr_wr) begin
         table_size_in = csr_pwdata[TSIZE_W-1:0];
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in      = KEY_WIDTH'(req_key);
               slot_in     = req_slot;
               w_placed_in = '0;
               w_home_in   = '0;
               w_mid_in    = '0;
               w_rkey_in   = '0;
               if (req_cmd == CMD_INSERT) begin
                  if (KEY_WIDTH'(req_key) == '0) begin
                     w_status_in = STAT_ZERO_KEY;
                     state_in    = S_DONE;
                  end else begin
                     state_in = S_SQ;
                  end
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_SQ: begin
            sq_in    = key_ff * key_ff;
            state_in = S_BCD_ST;
         end
         S_BCD_ST: begin
            bcd_start = 1'b1;
            state_in  = S_BCD;
         end
         S_BCD: begin
            if (bcd_done) begin
               state_in = S_MID;
            end
         end
         S_MID: begin
            w_mid_in   = mid_sel;
            div_in     = mid_sel;
            rem_in     = '0;
            mod_cnt_in = MOD_CNT_W'(MID_W);
            state_in   = S_MOD;
         end
         S_MOD: begin
            // restoring remainder, one bit of the middle value per cycle
            rem_in     = rem_next;
            div_in     = {div_ff[MID_W-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - MOD_CNT_W'(1);
            if (mod_cnt_ff == MOD_CNT_W'(1)) begin
               w_home_in    = SLOT_W'(rem_next);
               idx_in       = IDX_W'(rem_next);
               probe_cnt_in = '0;
               state_in     = S_PRB_RD;
            end
         end
         S_PRB_RD: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = idx_ff;
            state_in    = S_PRB_CHK;
         end
         S_PRB_CHK: begin
            if (tbl_rd_data == '0) begin
               tbl_wr_en   = 1'b1;
               w_status_in = STAT_STORED;
               w_placed_in = SLOT_W'(idx_ff);
               state_in    = S_DONE;
            end else if (SZ_W'(probe_cnt_ff + SZ_W'(1)) == eff_size) begin
               w_status_in = STAT_FULL;
               w_placed_in = '0;
               state_in    = S_DONE;
            end else begin
               idx_in       = (idx_inc == eff_size) ? '0 : IDX_W'(idx_inc);
               probe_cnt_in = probe_cnt_ff + SZ_W'(1);
               state_in     = S_PRB_RD;
            end
         end
         S_RD: begin
            tbl_rd_en   = slot_ok;
            tbl_rd_addr = IDX_W'(slot_ff);
            state_in    = S_RD_CHK;
         end
         S_RD_CHK: begin
            w_status_in = STAT_READ;
            w_placed_in = slot_ff;
            w_rkey_in   = slot_ok ? KEY_PORT_W'(tbl_rd_data) : '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               out_status_in = w_status_ff;
               out_placed_in = w_placed_ff;
               out_home_in   = w_home_ff;
               out_mid_in    = w_mid_ff;
               out_rkey_in   = w_rkey_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         table_size_ff <= TSIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      sq_ff         <= sq_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      mod_cnt_ff    <= mod_cnt_in;
      idx_ff        <= idx_in;
      probe_cnt_ff  <= probe_cnt_in;
      w_status_ff   <= w_status_in;
      w_placed_ff   <= w_placed_in;
      w_home_ff     <= w_home_in;
      w_mid_ff      <= w_mid_in;
      w_rkey_ff     <= w_rkey_in;
      out_status_ff <= out_status_in;
      out_placed_ff <= out_placed_in;
      out_home_ff   <= out_home_in;
      out_mid_ff    <= out_mid_in;
      out_rkey_ff   <= out_rkey_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_placed_slot = out_placed_ff;
   assign rsp_home_slot   = out_home_ff;
   assign rsp_mid_value   = out_mid_ff;
   assign rsp_read_key    = out_rkey_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_TABLE_SIZE_ADDR) ? CSR_DATA_W'(table_size_ff) : '0;

endmodule

// ===== rtl/msh_checker.sv =====
module msh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [msh_pkg::STAT_W-1:0]     rsp_status,
   input logic [msh_pkg::SLOT_W-1:0]     rsp_placed_slot,
   input logic [msh_pkg::SLOT_W-1:0]     rsp_home_slot,
   input logic [msh_pkg::MID_W-1:0]      rsp_mid_value,
   input logic [msh_pkg::KEY_PORT_W-1:0] rsp_read_key
);
   import msh_pkg::*;

   // a stalled result word holds its status, placed slot and read key
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_placed_slot) && $stable(rsp_read_key))
      else $error("result word changed under stall");

   // nothing pending and input open right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_READ |-> rsp_home_slot == '0 && rsp_mid_value == '0)
      else $error("read word carries hash fields");

   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ZERO_KEY |-> rsp_placed_slot == '0
         && rsp_home_slot == '0 && rsp_mid_value == '0 && rsp_read_key == '0)
      else $error("rejected key word not cleared");

   // home slot is the middle value reduced, so never above it
   a_insert_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_STORED || rsp_status == STAT_FULL)
         |-> rsp_read_key == '0 && rsp_mid_value <= MID_MAX
             && 7'(rsp_home_slot) <= rsp_mid_value)
      else $error("insert word fields out of range");

endmodule

bind mid_square_hash_linear_probe msh_checker u_msh_checker (.*);

// ===== tb/mid_square_hash_linear_probe_tb.sv =====
module mid_square_hash_linear_probe_tb;
   import msh_pkg::*;

   localparam int SLOTS       = 64;
   localparam int DEC_BASE    = 10;
   localparam int DIR_N       = 22;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 65;
   localparam int HOLD_CYCLES = 1500;
   localparam int DRAIN_WAIT  = 200;
   localparam int LIMIT       = 1000000;

   typedef struct packed {
      logic [STAT_W-1:0]     status;
      logic [SLOT_W-1:0]     placed;
      logic [SLOT_W-1:0]     home;
      logic [MID_W-1:0]      mid;
      logic [KEY_PORT_W-1:0] rkey;
   } probe_word_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [KEY_PORT_W-1:0] key;
      logic [SLOT_W-1:0]     slot;
      logic                  typed;
      probe_word_type        want;
   } stim_row_type;

   localparam probe_word_type NO_WANT = '0;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd     = CMD_INSERT;
   logic [KEY_PORT_W-1:0]   req_key     = '0;
   logic [SLOT_W-1:0]       req_slot    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic [STAT_W-1:0]       rsp_status;
   logic [SLOT_W-1:0]       rsp_placed_slot;
   logic [SLOT_W-1:0]       rsp_home_slot;
   logic [MID_W-1:0]        rsp_mid_value;
   logic [KEY_PORT_W-1:0]   rsp_read_key;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // predictor state
   logic [KEY_PORT_W-1:0] slot_keys [SLOTS];
   int unsigned           keys_stored = 0;
   logic [TSIZE_W-1:0]    tsize_cfg   = TSIZE_RESET;

   probe_word_type pending [$];
   int          mismatches     = 0;
   int          cycle_cnt      = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_gen       = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;

   stim_row_type dir_rows [DIR_N] = '{
      '{CMD_READ,   16'h0000, 6'd0,  1'b1, '{STAT_READ, 6'd0, 6'd0, 7'd0, 16'h0000}},
      '{CMD_READ,   16'hFFFF, 6'd63, 1'b1, '{STAT_READ, 6'd63, 6'd0, 7'd0, 16'h0000}},
      '{CMD_INSERT, 16'h0000, 6'd0,  1'b1, '{STAT_ZERO_KEY, 6'd0, 6'd0, 7'd0, 16'h0000}},
      '{CMD_INSERT, 16'h0000, 6'd63, 1'b1, '{STAT_ZERO_KEY, 6'd0, 6'd0, 7'd0, 16'h0000}},
      '{CMD_INSERT, 16'd1,     6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'hFFFF,  6'd63, 1'b0, NO_WANT},
      '{CMD_INSERT, 16'd1,     6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'hFFFF,  6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'h8000,  6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'h5555,  6'h2A, 1'b0, NO_WANT},
      '{CMD_INSERT, 16'hAAAA,  6'h15, 1'b0, NO_WANT},
      '{CMD_INSERT, 16'h00FF,  6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'hFF00,  6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'd3,     6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'd10,    6'd0,  1'b0, NO_WANT},
      '{CMD_INSERT, 16'd32,    6'd0,  1'b0, NO_WANT},
      '{CMD_READ,   16'h0000,  6'd1,  1'b0, NO_WANT},
      '{CMD_READ,   16'h0000,  6'd2,  1'b0, NO_WANT},
      '{CMD_READ,   16'hFFFF,  6'd19, 1'b0, NO_WANT},
      '{CMD_READ,   16'h0000,  6'd20, 1'b0, NO_WANT},
      '{CMD_READ,   16'h5555,  6'h2A, 1'b0, NO_WANT},
      '{CMD_READ,   16'hAAAA,  6'h15, 1'b0, NO_WANT}
   };

   // progressive sizes so stores keep happening across the run; 0 and 127 clamp
   int ph_size [PHASES] = '{1, 0, 3, 8, 2, 20, 13, 40, 127, 64};
   int send_pct_by_mode [4] = '{0, 78, 0, 12};
   int recv_pct_by_mode [4] = '{0, 0, 78, 12};

   mid_square_hash_linear_probe u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_placed_slot (rsp_placed_slot),
      .rsp_home_slot   (rsp_home_slot),
      .rsp_mid_value   (rsp_mid_value),
      .rsp_read_key    (rsp_read_key),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // middle one or two decimal digits of a nonzero square
   function automatic logic [MID_W-1:0] middle_digits(input logic [31:0] sq);
      longint unsigned rest;
      longint unsigned scale;
      int unsigned     ndig;
      int unsigned     k;
      int unsigned     d_lo;
      int unsigned     d_hi;
      rest = sq;
      ndig = 0;
      while (rest != 0) begin
         rest = rest / DEC_BASE;
         ndig++;
      end
      if (ndig == 0) return '0;
      scale = 1;
      for (k = 0; k < ndig - 1 - ndig / 2; k++) scale = scale * DEC_BASE;
      d_lo = 32'((sq / scale) % DEC_BASE);
      if (ndig % 2 == 1) return MID_W'(d_lo);
      scale = 1;
      for (k = 0; k < ndig - 1 - (ndig - 1) / 2; k++) scale = scale * DEC_BASE;
      d_hi = 32'((sq / scale) % DEC_BASE);
      return MID_W'(d_hi * DEC_BASE + d_lo);
   endfunction

   // read a slot, or hash the key, probe upward with wrap, update the table copy
   function automatic probe_word_type probe_table(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_PORT_W-1:0] key,
                                                  input logic [SLOT_W-1:0] slot);
      probe_word_type w;
      logic [31:0] k32;
      int unsigned size;
      int unsigned idx;
      int unsigned i;
      bit          done;
      w = '0;
      if (cmd == CMD_READ) begin
         w.status = STAT_READ;
         w.placed = slot;
         w.rkey   = slot_keys[slot];
      end else if (key == '0) begin
         w.status = STAT_ZERO_KEY;
      end else begin
         size = tsize_cfg;
         if (size < 1) size = 1;
         if (size > SLOTS) size = SLOTS;
         k32 = key;
         w.mid    = middle_digits(k32 * k32);
         w.home   = SLOT_W'(w.mid % size);
         w.status = STAT_FULL;
         idx  = w.home;
         done = 1'b0;
         for (i = 0; i < size && !done; i++) begin
            if (slot_keys[idx] == '0) begin
               slot_keys[idx] = key;
               w.placed = SLOT_W'(idx);
               w.status = STAT_STORED;
               done = 1'b1;
               if (keys_stored < SLOTS) keys_stored++;
            end else begin
               idx = (idx + 1) % size;
            end
         end
      end
      return w;
   endfunction

   task automatic offer_word(input stim_row_type row);
      probe_word_type guess;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= row.cmd;
      req_key   <= row.key;
      req_slot  <= row.slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = probe_table(row.cmd, row.key, row.slot);
      pending.push_back(row.typed ? row.want : guess);
   endtask

   task automatic wait_drained;
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [TSIZE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_TABLE_SIZE_ADDR;
      csr_pwdata  <= {{(CSR_DATA_W - TSIZE_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tsize_cfg = value;
   endtask

   // receiver: random stall, or a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_gen) begin
         hold_seen <= hold_gen;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      probe_word_type got;
      probe_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_placed_slot, rsp_home_slot, rsp_mid_value, rsp_read_key};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: status %0d placed %0d home %0d mid %0d key %h",
                        got.status, got.placed, got.home, got.mid, got.rkey);
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status || got.placed !== want.placed ||
                got.home !== want.home || got.mid !== want.mid || got.rkey !== want.rkey) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: exp status %0d placed %0d home %0d mid %0d key %h, ",
                         want.status, want.placed, want.home, want.mid, want.rkey);
                  $display("got status %0d placed %0d home %0d mid %0d key %h",
                           got.status, got.placed, got.home, got.mid, got.rkey);
               end
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int        p;
      int        n;
      int        pick;
      foreach (slot_keys[j]) slot_keys[j] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIR_N; n++) offer_word(dir_rows[n]);
      req_valid <= 1'b0;
      wait_drained();

      for (p = 0; p < PHASES; p++) begin
         write_table_size(TSIZE_W'(ph_size[p]));
         send_idle_pct  = send_pct_by_mode[p % 4];
         recv_stall_pct = recv_pct_by_mode[p % 4];
         if (p == PHASES - 1) begin
            // long receiver hold-off while words keep coming: block backs up
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_gen++;
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            pick     = $urandom_range(99);
            row      = '0;
            row.slot = SLOT_W'($urandom_range(63));
            row.key  = KEY_PORT_W'($urandom);
            if (pick < 35) begin
               row.cmd = CMD_READ;
            end else begin
               row.cmd = CMD_INSERT;
               if (pick < 41) row.key = '0;
               else if (pick < 60) row.key = KEY_PORT_W'($urandom_range(999, 1));
            end
            offer_word(row);
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
